// ===== rtl/core/afmr_pkg.sv =====
`timescale 1ns / 1ps

package afmr_pkg;

	localparam int SMP_W  = 24;
	localparam int GAIN_W = 25;
	localparam int FRAC_W = 23;
	localparam int LVL_W  = 8;
	localparam int LEN_W  = 7;

	localparam logic [GAIN_W-1:0] UNITY_GAIN = 25'd8388608;

	localparam int QDEPTH = 4;
	localparam int QPTR_W = 2;
	localparam int QCNT_W = 3;

	typedef struct packed {
		logic signed [SMP_W-1:0] left_in;
		logic signed [SMP_W-1:0] right_in;
		logic                    block_start;
		logic                    fade_req;
		logic [LEN_W-1:0]        block_len;
	} sample_t;

	typedef struct packed {
		logic signed [SMP_W-1:0] left_out;
		logic signed [SMP_W-1:0] right_out;
		logic                    muted;
		logic [LVL_W-1:0]        fade_level;
	} result_t;

	typedef struct packed {
		logic signed [SMP_W-1:0] left;
		logic signed [SMP_W-1:0] right;
		logic [GAIN_W-1:0]       gain;
		logic                    muted;
		logic [LVL_W-1:0]        level;
	} work_t;

	typedef struct packed {
		logic              full;
		logic              empty;
		logic [QCNT_W-1:0] count;
	} q_stat_t;

endpackage

// ===== rtl/core/audio_fade_mute_ramp.sv =====
`timescale 1ns / 1ps

// Stereo soft-mute gain ramp. One sample transaction is taken per clock while the queue is
// not full (the front writes its gain update into a four-entry queue at the accepting edge,
// then one multiply stage, then one output register drive result_valid). The rate of one per
// clock is set by the front's gain accumulator, which advances once per accepted transaction
// and applies the block update of fade count, direction and step on the transaction marked
// block_start. A stalled output backs the queue up; sample_ready drops only when the queue is
// full.
module audio_fade_mute_ramp
	import afmr_pkg::*;
#(
	parameter int FADE_STEPS   = 96,
	parameter int SILENT_STEPS = 128,
	parameter int MAX_BLOCK    = 64
) (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    sample_valid,
	output logic    sample_ready,
	input  sample_t sample,
	output logic    result_valid,
	input  logic    result_ready,
	output result_t result
);

	logic    take;
	logic    pop;
	work_t   wk_in;
	work_t   wk_out;
	q_stat_t stat;

	assign sample_ready = !stat.full;
	assign take         = sample_valid && sample_ready;

	afmr_front #(
		.FADE_STEPS  (FADE_STEPS),
		.SILENT_STEPS(SILENT_STEPS),
		.MAX_BLOCK   (MAX_BLOCK)
	) u_front (
		.clk   (clk),
		.arst_n(arst_n),
		.sample(sample),
		.take  (take),
		.work  (wk_in)
	);

	afmr_fifo u_fifo (
		.clk   (clk),
		.arst_n(arst_n),
		.push  (take),
		.wdata (wk_in),
		.pop   (pop),
		.rdata (wk_out),
		.stat  (stat)
	);

	afmr_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.q_valid  (!stat.empty),
		.q_data   (wk_out),
		.q_pop    (pop),
		.res_valid(result_valid),
		.res      (result),
		.res_ready(result_ready)
	);

`ifndef ASSERT_OFF
	ap_q_bound: assert property (@(posedge clk) disable iff (!arst_n)
		stat.count <= QCNT_W'(QDEPTH))
		else $error("queue count above depth");

	ap_muted_zero: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result.muted |-> result.left_out == '0 && result.right_out == '0)
		else $error("muted transaction carries nonzero samples");

	ap_muted_level: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result.muted |->
		({1'b0, result.fade_level} + 9'd1) >= 9'(FADE_STEPS))
		else $error("muted transaction with fade level below mute range");

	ap_pop_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> stat.count != '0 && !(stat.count == QCNT_W'(QDEPTH) && take))
		else $error("queue popped while empty or pushed while full");
`endif

endmodule

// ===== rtl/core/afmr_front.sv =====
`timescale 1ns / 1ps

module afmr_front
	import afmr_pkg::*;
#(
	parameter int FADE_STEPS   = 96,
	parameter int SILENT_STEPS = 128,
	parameter int MAX_BLOCK    = 64
) (
	input  logic    clk,
	input  logic    arst_n,
	input  sample_t sample,
	input  logic    take,
	output work_t   work
);

	localparam int GI_W = $clog2(FADE_STEPS + 1);
	localparam int GN   = 2 ** GI_W;
	localparam int NI_W = (MAX_BLOCK > 1) ? $clog2(MAX_BLOCK) : 1;
	localparam logic [63:0] DSTEP = (64'd1 << FRAC_W) / FADE_STEPS;

	localparam logic [LVL_W-1:0] FADE_C   = LVL_W'(FADE_STEPS);
	localparam logic [LVL_W-1:0] SILENT_C = LVL_W'(SILENT_STEPS);
	localparam logic [8:0]       MAX_C    = 9'(MAX_BLOCK);

	logic [GAIN_W-1:0] gain_tab [GN];
	logic              hi_tab   [GN];
	logic [GAIN_W-1:0] qlo_tab  [MAX_BLOCK];
	logic [GAIN_W-1:0] qhi_tab  [MAX_BLOCK];

	for (genvar f = 0; f < GN; f++) begin : g_gain
		localparam logic [63:0] GV = (f < FADE_STEPS) ?
			((64'(FADE_STEPS - f)) << FRAC_W) / FADE_STEPS : 64'd0;
		localparam logic [63:0] GW = (f + 1 < FADE_STEPS) ?
			((64'(FADE_STEPS - f - 1)) << FRAC_W) / FADE_STEPS : 64'd0;
		assign gain_tab[f] = GV[GAIN_W-1:0];
		assign hi_tab[f]   = ((GV - GW) == (DSTEP + 64'd1));
	end

	for (genvar n = 0; n < MAX_BLOCK; n++) begin : g_step
		localparam logic [63:0] QL = DSTEP / (n + 1);
		localparam logic [63:0] QH = (DSTEP + 64'd1) / (n + 1);
		assign qlo_tab[n] = QL[GAIN_W-1:0];
		assign qhi_tab[n] = QH[GAIN_W-1:0];
	end

	logic [LVL_W-1:0]         cnt_q;
	logic                     fading_q;
	logic                     muted_q;
	logic [GAIN_W-1:0]        gain_q;
	logic signed [GAIN_W-1:0] step_q;

	logic                     fo;
	logic                     fo_d;
	logic                     muted_d;
	logic                     ramp;
	logic                     up;
	logic [LVL_W-1:0]         cnt_d;
	logic [LVL_W-1:0]         fmin;
	logic [8:0]               n_sel;
	logic [8:0]               nm1;
	logic [GAIN_W-1:0]        mag;
	logic signed [GAIN_W-1:0] q;
	logic [GAIN_W-1:0]        base;
	logic signed [GAIN_W-1:0] step;
	logic signed [GAIN_W+1:0] sum;
	logic [GAIN_W-1:0]        gain_nx;

	always_comb begin
		fo      = fading_q | sample.fade_req;
		cnt_d   = cnt_q;
		fo_d    = fo;
		muted_d = 1'b0;
		ramp    = 1'b0;
		up      = 1'b0;
		if (!fo && cnt_q != '0 && cnt_q <= FADE_C) begin
			cnt_d = cnt_q - LVL_W'(1);
			ramp  = 1'b1;
		end else if (fo && cnt_q < FADE_C) begin
			cnt_d = cnt_q + LVL_W'(1);
			ramp  = 1'b1;
			up    = 1'b1;
		end else if (cnt_q >= FADE_C) begin
			muted_d = 1'b1;
			if (!fo) begin
				cnt_d = cnt_q - LVL_W'(1);
			end else if (cnt_q < SILENT_C) begin
				cnt_d = cnt_q + LVL_W'(1);
			end else if (!sample.fade_req) begin
				fo_d = 1'b0;
			end
		end
	end

	always_comb begin
		fmin = up ? cnt_q : cnt_q - LVL_W'(1);
		if (sample.block_len == '0) begin
			n_sel = 9'd1;
		end else if (9'(sample.block_len) > MAX_C) begin
			n_sel = MAX_C;
		end else begin
			n_sel = 9'(sample.block_len);
		end
		nm1 = n_sel - 9'd1;
		mag = hi_tab[fmin[GI_W-1:0]] ? qhi_tab[nm1[NI_W-1:0]] : qlo_tab[nm1[NI_W-1:0]];
		q   = up ? -$signed(mag) : $signed(mag);

		if (sample.block_start) begin
			base = ramp ? gain_tab[cnt_q[GI_W-1:0]] : UNITY_GAIN;
			step = ramp ? q : '0;
		end else begin
			base = gain_q;
			step = step_q;
		end

		sum = $signed({2'b00, base}) + $signed({{2{step[GAIN_W-1]}}, step});
		if (sum < 0) begin
			gain_nx = '0;
		end else if (sum > $signed({2'b00, UNITY_GAIN})) begin
			gain_nx = UNITY_GAIN;
		end else begin
			gain_nx = sum[GAIN_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q    <= '0;
			fading_q <= 1'b0;
			muted_q  <= 1'b0;
			gain_q   <= UNITY_GAIN;
			step_q   <= '0;
		end else if (take) begin
			gain_q <= gain_nx;
			if (sample.block_start) begin
				cnt_q    <= cnt_d;
				fading_q <= fo_d;
				muted_q  <= muted_d;
				step_q   <= step;
			end
		end
	end

	always_comb begin
		work.left  = sample.left_in;
		work.right = sample.right_in;
		work.gain  = gain_nx;
		work.muted = sample.block_start ? muted_d : muted_q;
		work.level = sample.block_start ? cnt_d : cnt_q;
	end

endmodule

// ===== rtl/core/afmr_fifo.sv =====
`timescale 1ns / 1ps

module afmr_fifo
	import afmr_pkg::*;
(
	input  logic    clk,
	input  logic    arst_n,
	input  logic    push,
	input  work_t   wdata,
	input  logic    pop,
	output work_t   rdata,
	output q_stat_t stat
);

	work_t             mem [QDEPTH];
	logic [QPTR_W-1:0] wr_q;
	logic [QPTR_W-1:0] rd_q;
	logic [QCNT_W-1:0] cnt_q;

	always_ff @(posedge clk) begin
		if (push) begin
			mem[wr_q] <= wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wr_q <= wr_q + QPTR_W'(1);
			end
			if (pop) begin
				rd_q <= rd_q + QPTR_W'(1);
			end
			case ({push, pop})
				2'b10:   cnt_q <= cnt_q + QCNT_W'(1);
				2'b01:   cnt_q <= cnt_q - QCNT_W'(1);
				default: cnt_q <= cnt_q;
			endcase
		end
	end

	assign rdata      = mem[rd_q];
	assign stat.full  = (cnt_q == QCNT_W'(QDEPTH));
	assign stat.empty = (cnt_q == '0);
	assign stat.count = cnt_q;

endmodule

// ===== rtl/core/afmr_back.sv =====
`timescale 1ns / 1ps

module afmr_back
	import afmr_pkg::*;
(
	input  logic    clk,
	input  logic    arst_n,
	input  logic    q_valid,
	input  work_t   q_data,
	output logic    q_pop,
	output logic    res_valid,
	output result_t res,
	input  logic    res_ready
);

	localparam int PROD_W = SMP_W + GAIN_W + 1;
	localparam int SHR_W  = PROD_W - FRAC_W;

	logic                     valid_s1;
	logic signed [PROD_W-1:0] prod_l_s1;
	logic signed [PROD_W-1:0] prod_r_s1;
	logic                     muted_s1;
	logic [LVL_W-1:0]         level_s1;
	logic                     res_valid_q;
	result_t                  res_q;
	logic                     out_adv;
	logic                     s1_adv;

	function automatic logic signed [SMP_W-1:0] sat_smp(input logic signed [PROD_W-1:0] p);
		logic signed [SHR_W-1:0] v;
		v = p[PROD_W-1:FRAC_W];
		if (v > $signed(SHR_W'(8388607))) begin
			sat_smp = 24'sh7FFFFF;
		end else if (v < -$signed(SHR_W'(8388608))) begin
			sat_smp = 24'sh800000;
		end else begin
			sat_smp = v[SMP_W-1:0];
		end
	endfunction

	assign out_adv = !res_valid_q || res_ready;
	assign s1_adv  = !valid_s1 || out_adv;
	assign q_pop   = q_valid && s1_adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			res_valid_q <= 1'b0;
		end else begin
			if (s1_adv) begin
				valid_s1 <= q_valid;
			end
			if (out_adv) begin
				res_valid_q <= valid_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (q_pop) begin
			prod_l_s1 <= PROD_W'(q_data.left) * PROD_W'($signed({1'b0, q_data.gain}));
			prod_r_s1 <= PROD_W'(q_data.right) * PROD_W'($signed({1'b0, q_data.gain}));
			muted_s1  <= q_data.muted;
			level_s1  <= q_data.level;
		end
		if (valid_s1 && out_adv) begin
			res_q.left_out   <= muted_s1 ? '0 : sat_smp(prod_l_s1);
			res_q.right_out  <= muted_s1 ? '0 : sat_smp(prod_r_s1);
			res_q.muted      <= muted_s1;
			res_q.fade_level <= level_s1;
		end
	end

	assign res_valid = res_valid_q;
	assign res       = res_q;

endmodule

// ===== tb/sv/audio_fade_mute_ramp_tb.sv =====
`timescale 1ns / 1ps

module audio_fade_mute_ramp_tb;
	import afmr_pkg::*;

	localparam int FADE_STEPS   = 96;
	localparam int SILENT_STEPS = 128;
	localparam int MAX_BLOCK    = 64;
	localparam int N_ITEMS      = 1600;
	localparam int HOLD_CYCLES  = 64;
	localparam longint UNITY    = longint'(UNITY_GAIN);

	typedef struct {
		sample_t s;
		bit      typed;
		result_t want;
	} stim_row_t;

	logic    clk;
	logic    arst_n;
	logic    sample_valid;
	logic    sample_ready;
	sample_t sample;
	logic    result_valid;
	logic    result_ready;
	result_t result;

	int          n_sent;
	int          n_mismatch;
	logic        steady;
	bit          row_typed;
	result_t     row_want;
	result_t     frame_pred;
	result_t     frame_want;
	result_t     faded_frames[$];
	stim_row_t   directed_rows[$];

	int unsigned fade_cnt;
	bit          fade_dir_out;
	bit          silenced;
	longint      gain_acc;
	longint      gain_inc;

	assign steady = (n_sent >= 800) && (n_sent < 1100);

	audio_fade_mute_ramp i_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.sample_valid (sample_valid),
		.sample_ready (sample_ready),
		.sample       (sample),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.result       (result)
	);

	initial clk = 1'b0;
	always #10 clk = ~clk;

	initial begin
		#2ms;
		$display("audio_fade_mute_ramp: mismatch");
		$finish;
	end

	function automatic longint ramp_gain(input int unsigned f);
		if (f >= FADE_STEPS)
			return 0;
		return (longint'(FADE_STEPS - f) << FRAC_W) / FADE_STEPS;
	endfunction

	function automatic logic [SMP_W-1:0] scale_sample(input logic signed [SMP_W-1:0] x,
			input longint g);
		longint p;
		p = longint'(x) * g;
		p = p >>> FRAC_W;
		if (p > 8388607)
			p = 8388607;
		if (p < -8388608)
			p = -8388608;
		return p[SMP_W-1:0];
	endfunction

	function automatic void update_block(input bit req, input logic [LEN_W-1:0] len);
		int unsigned n;
		int unsigned f0;
		bit          ramp;
		n = 32'(len);
		if (len == 0)
			n = 1;
		if (len > MAX_BLOCK)
			n = MAX_BLOCK;
		f0 = fade_cnt;
		ramp = 1'b0;
		if (req)
			fade_dir_out = 1'b1;
		silenced = 1'b0;
		if (!fade_dir_out && fade_cnt > 0 && fade_cnt <= FADE_STEPS) begin
			fade_cnt--;
			ramp = 1'b1;
		end else if (fade_dir_out && fade_cnt < FADE_STEPS) begin
			fade_cnt++;
			ramp = 1'b1;
		end else if (fade_cnt >= FADE_STEPS) begin
			if (!fade_dir_out)
				fade_cnt--;
			else if (fade_cnt < SILENT_STEPS)
				fade_cnt++;
			else if (!req)
				fade_dir_out = 1'b0;
			silenced = 1'b1;
		end
		if (ramp) begin
			gain_acc = ramp_gain(f0);
			gain_inc = (ramp_gain(fade_cnt) - ramp_gain(f0)) / longint'(n);
		end else begin
			gain_acc = UNITY;
			gain_inc = 0;
		end
	endfunction

	function automatic result_t fade_frame(input sample_t s);
		result_t r;
		if (s.block_start)
			update_block(s.fade_req, s.block_len);
		gain_acc = gain_acc + gain_inc;
		if (gain_acc < 0)
			gain_acc = 0;
		if (gain_acc > UNITY)
			gain_acc = UNITY;
		if (silenced) begin
			r.left_out  = '0;
			r.right_out = '0;
		end else begin
			r.left_out  = scale_sample(s.left_in, gain_acc);
			r.right_out = scale_sample(s.right_in, gain_acc);
		end
		r.muted      = silenced;
		r.fade_level = fade_cnt[LVL_W-1:0];
		return r;
	endfunction

	task automatic flag_mismatch(input string what, input longint got, input longint want);
		n_mismatch++;
		if (n_mismatch <= 100)
			$display("[%0t] %s: got %0d, want %0d", $time, what, got, want);
	endtask

	always @(posedge clk) begin
		if (arst_n) begin
			if (sample_valid && sample_ready) begin
				frame_pred = fade_frame(sample);
				faded_frames.push_back(row_typed ? row_want : frame_pred);
			end
			if (result_valid && result_ready) begin
				if (faded_frames.size() == 0) begin
					flag_mismatch("result transaction with nothing pending",
						longint'(result.fade_level), -1);
				end else begin
					frame_want = faded_frames.pop_front();
					if (result.left_out !== frame_want.left_out)
						flag_mismatch("left_out", longint'(result.left_out),
							longint'(frame_want.left_out));
					if (result.right_out !== frame_want.right_out)
						flag_mismatch("right_out", longint'(result.right_out),
							longint'(frame_want.right_out));
					if (result.muted !== frame_want.muted)
						flag_mismatch("muted", longint'(result.muted),
							longint'(frame_want.muted));
					if (result.fade_level !== frame_want.fade_level)
						flag_mismatch("fade_level", longint'(result.fade_level),
							longint'(frame_want.fade_level));
				end
			end
		end
	end

	function automatic void add_row(input int l, input int r, input bit bs, input bit nf,
			input int len, input bit typed, input int lo, input int ro, input bit m,
			input int lvl);
		stim_row_t row;
		row.s.left_in         = l[SMP_W-1:0];
		row.s.right_in        = r[SMP_W-1:0];
		row.s.block_start     = bs;
		row.s.fade_req        = nf;
		row.s.block_len       = len[LEN_W-1:0];
		row.typed             = typed;
		row.want.left_out     = lo[SMP_W-1:0];
		row.want.right_out    = ro[SMP_W-1:0];
		row.want.muted        = m;
		row.want.fade_level   = lvl[LVL_W-1:0];
		directed_rows.push_back(row);
	endfunction

	function automatic logic [SMP_W-1:0] pick_sample();
		case ($urandom_range(15))
			0: return 24'h7FFFFF;
			1: return 24'h800000;
			2: return '0;
			default: return SMP_W'($urandom);
		endcase
	endfunction

	task automatic push_sample(input sample_t s, input bit typed, input result_t want);
		while (!steady && $urandom_range(99) < 14) begin
			sample_valid <= 1'b0;
			@(negedge clk);
		end
		sample_valid <= 1'b1;
		sample       <= s;
		row_typed    = typed;
		row_want     = want;
		do
			@(posedge clk);
		while (!sample_ready);
		n_sent++;
		@(negedge clk);
	endtask

	initial begin
		bit      hold_done;
		hold_done    = 1'b0;
		result_ready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (!hold_done && n_sent >= 400) begin
				hold_done = 1'b1;
				result_ready <= 1'b0;
				repeat (HOLD_CYCLES) @(negedge clk);
			end
			result_ready <= steady || ($urandom_range(99) >= 14);
		end
	end

	initial begin
		bit      req;
		int      req_blocks;
		int      len_code;
		int      eff;
		int      nsamp;
		sample_t s;
		result_t none;

		arst_n       = 1'b0;
		sample_valid = 1'b0;
		sample       = '0;
		row_typed    = 1'b0;
		row_want     = '0;
		n_sent       = 0;
		n_mismatch   = 0;
		fade_cnt     = 0;
		fade_dir_out = 1'b0;
		silenced     = 1'b0;
		gain_acc     = UNITY;
		gain_inc     = 0;
		none         = '0;

		// with no fade requested at a block start, samples pass at unity gain
		add_row( 8388607, -8388608, 0, 1,   5, 1,  8388607, -8388608, 0, 0);
		add_row(      -1,        1, 1, 0,   0, 1,       -1,        1, 0, 0);
		add_row(       0,        0, 0, 0, 127, 1,        0,        0, 0, 0);
		add_row( 2796202, -5592406, 1, 0, 127, 1,  2796202, -5592406, 0, 0);
		// fade out: step per block, lengths zero and above the maximum
		add_row( 8388607, -8388608, 1, 1,   1, 0, 0, 0, 0, 0);
		add_row( 8388607, -8388608, 0, 0,   0, 0, 0, 0, 0, 0);
		add_row(-8388608,  8388607, 0, 1,  64, 0, 0, 0, 0, 0);
		add_row( 4194304, -4194304, 1, 1,   0, 0, 0, 0, 0, 0);
		add_row(       1,       -1, 1, 1, 100, 0, 0, 0, 0, 0);
		add_row( 8388607,  8388607, 0, 0,   3, 0, 0, 0, 0, 0);
		add_row(-8388608, -8388608, 0, 0,   0, 0, 0, 0, 0, 0);
		add_row(    1000,    -1000, 1, 1,  64, 0, 0, 0, 0, 0);
		add_row( 8388607, -8388608, 0, 0,  64, 0, 0, 0, 0, 0);
		add_row( 5000000, -3000000, 0, 1,   1, 0, 0, 0, 0, 0);
		add_row(-8388608,  8388607, 0, 0, 127, 0, 0, 0, 0, 0);
		add_row(       2,       -2, 0, 0,   0, 0, 0, 0, 0, 0);
		// block starts with the request low; the latched fade out goes on
		add_row( 8388607, -8388608, 1, 0,   3, 0, 0, 0, 0, 0);
		add_row( 8388607, -8388608, 0, 1,   9, 0, 0, 0, 0, 0);
		add_row(-8388608,  8388607, 0, 0,   0, 0, 0, 0, 0, 0);
		add_row( 3333333, -7777777, 1, 0,   2, 0, 0, 0, 0, 0);
		add_row( 8388607, -8388608, 1, 0,   1, 0, 0, 0, 0, 0);
		add_row( 8388607, -8388608, 1, 0,   1, 0, 0, 0, 0, 0);
		add_row( 8388607, -8388608, 1, 0,  64, 0, 0, 0, 0, 0);

		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		foreach (directed_rows[i])
			push_sample(directed_rows[i].s, directed_rows[i].typed, directed_rows[i].want);

		// blocks with random content; requests mostly held long enough to reach full mute
		req        = 1'b0;
		req_blocks = 0;
		while (n_sent < N_ITEMS) begin
			if (req_blocks == 0) begin
				req = !req;
				req_blocks = ($urandom_range(3) == 0) ? $urandom_range(12, 1) :
					$urandom_range(170, 100);
			end
			req_blocks--;
			case ($urandom_range(19))
				0: len_code = 0;
				1: len_code = $urandom_range(127, MAX_BLOCK + 1);
				2: len_code = $urandom_range(MAX_BLOCK, 5);
				default: len_code = $urandom_range(4, 1);
			endcase
			eff = (len_code == 0) ? 1 : ((len_code > MAX_BLOCK) ? MAX_BLOCK : len_code);
			if (len_code > MAX_BLOCK)
				nsamp = $urandom_range(4, 1);
			else if ($urandom_range(7) == 0)
				nsamp = $urandom_range(eff + 3, 1);
			else
				nsamp = eff;
			for (int k = 0; k < nsamp; k++) begin
				s.left_in     = pick_sample();
				s.right_in    = pick_sample();
				s.block_start = (k == 0);
				if (k == 0) begin
					s.fade_req  = ($urandom_range(19) == 0) ? !req : req;
					s.block_len = len_code[LEN_W-1:0];
				end else begin
					s.fade_req  = 1'($urandom);
					s.block_len = LEN_W'($urandom);
				end
				push_sample(s, 1'b0, none);
			end
		end
		sample_valid <= 1'b0;

		while (faded_frames.size() != 0)
			@(posedge clk);
		repeat (20) @(posedge clk);

		if (n_mismatch == 0 && faded_frames.size() == 0)
			$display("audio_fade_mute_ramp: match");
		else
			$display("audio_fade_mute_ramp: mismatch");
		$finish;
	end

endmodule

// ===== filelist.f =====
rtl/core/afmr_pkg.sv
rtl/core/afmr_front.sv
rtl/core/afmr_fifo.sv
rtl/core/afmr_back.sv
rtl/core/audio_fade_mute_ramp.sv
tb/sv/audio_fade_mute_ramp_tb.sv
